/* rtl/core/lr_shift_reduce_parser_macros.svh */
// ----------------------------------------------------------------------------
// lr_shift_reduce_parser_macros
// Assertion helper macros for the LR parser block.
// ----------------------------------------------------------------------------
`ifndef LR_SHIFT_REDUCE_PARSER_MACROS_SVH
`define LR_SHIFT_REDUCE_PARSER_MACROS_SVH
// Check that a condition implies a consequence at the same edge
`define LRP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrp check failed");
// Check that a condition implies a consequence at the next edge
`define LRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrp check failed");
`endif

/* rtl/core/lrp_pkg.sv */
// ----------------------------------------------------------------------------
// lrp_pkg
// Types and codes shared by the LR parser block.
// ----------------------------------------------------------------------------
package lrp_pkg;

    localparam int unsigned ActW   = 2;
    localparam int unsigned StateW = 8;
    localparam int unsigned SymW   = 6;
    localparam int unsigned KindW  = 2;
    localparam int unsigned RuleW  = 7;
    localparam int unsigned LenW   = 4;
    localparam int unsigned EvW    = 3;
    localparam int unsigned DepthW = 7;

    typedef enum logic [ActW-1:0] {
        ACT_WR_TABLE = 2'd0,
        ACT_WR_RULE  = 2'd1,
        ACT_START    = 2'd2,
        ACT_TOKEN    = 2'd3
    } t_act;

    typedef enum logic [KindW-1:0] {
        KIND_ERROR  = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_REDUCE = 2'd2,
        KIND_ACCEPT = 2'd3
    } t_kind;

    typedef enum logic [EvW-1:0] {
        EV_ACK      = 3'd0,
        EV_SHIFT    = 3'd1,
        EV_REDUCE   = 3'd2,
        EV_ACCEPT   = 3'd3,
        EV_SYNTAX   = 3'd4,
        EV_BAD_GOTO = 3'd5,
        EV_STACK    = 3'd6,
        EV_IDLE     = 3'd7
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACT_RD,
        ST_RULE_RD,
        ST_GOTO_RD,
        ST_GOTO_EV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [ActW-1:0]   action;
        logic [StateW-1:0] table_state;
        logic [SymW-1:0]   table_symbol;
        logic [KindW-1:0]  entry_kind;
        logic [StateW-1:0] entry_value;
        logic [RuleW-1:0]  rule_index;
        logic [LenW-1:0]   rule_length;
        logic [SymW-1:0]   rule_head;
        logic [SymW-1:0]   token;
    } t_in_item;

    typedef struct packed {
        logic [EvW-1:0]    event_res;
        logic [RuleW-1:0]  production;
        logic [StateW-1:0] state_after;
        logic [DepthW-1:0] depth;
        logic              last;
    } t_out_item;

endpackage

/* rtl/core/lrp_if.sv */
// ----------------------------------------------------------------------------
// lrp_in_if / lrp_out_if
// Valid/ready channels carrying parser input items and result items.
// ----------------------------------------------------------------------------
interface lrp_in_if;
    logic               valid;
    logic               ready;
    lrp_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lrp_out_if;
    logic               valid;
    logic               ready;
    lrp_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/lrp_mem.sv */
// ----------------------------------------------------------------------------
// lrp_mem
// Single-port-write, one-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module lrp_mem #(
    parameter int unsigned AW = 8,
    parameter int unsigned DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/lr_shift_reduce_parser.sv */
// Sequence: a load, start or idle item passes through ST_EMIT to its result.
//   A token ends on its last result after its reductions; each
//   reduction is an action, rule, stack and goto read in sequence.
// Flow: one item at a time; the next transfer can coincide with the last
//   result, and any output stall holds the block.
// Reset: i_rst_n synchronous active low; clears control, depth, parse flag.
// ----------------------------------------------------------------------------
// lr_shift_reduce_parser
// Table-driven LR parser driver built around table, rule and stack memories.
// Table, rule and stack memories are undefined until written.
// ----------------------------------------------------------------------------
`include "lr_shift_reduce_parser_macros.svh"
module lr_shift_reduce_parser #(
    parameter int unsigned NUM_STATES  = 256,
    parameter int unsigned NUM_SYMBOLS = 64,
    parameter int unsigned NUM_RULES   = 128,
    parameter int unsigned STACK_DEPTH = 64,
    parameter int unsigned MAX_REDUCES = 63
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lrp_in_if.sink    i_in,
    lrp_out_if.source o_out
);
    localparam int unsigned StW  = lrp_pkg::StateW;
    localparam int unsigned SyW  = lrp_pkg::SymW;
    localparam int unsigned DW   = lrp_pkg::DepthW;
    // Rows, columns and productions beyond the field widths are unreachable.
    localparam int unsigned SAW  = (NUM_STATES > 1) ?
        (($clog2(NUM_STATES) > StW) ? StW : $clog2(NUM_STATES)) : 1;
    localparam int unsigned YAW  = (NUM_SYMBOLS > 1) ?
        (($clog2(NUM_SYMBOLS) > SyW) ? SyW : $clog2(NUM_SYMBOLS)) : 1;
    localparam int unsigned RAW  = (NUM_RULES > 1) ?
        (($clog2(NUM_RULES) > lrp_pkg::RuleW) ? lrp_pkg::RuleW : $clog2(NUM_RULES)) : 1;
    localparam int unsigned KAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned TAW  = SAW + YAW;
    localparam int unsigned TDW  = lrp_pkg::KindW + StW;
    localparam int unsigned RDW  = lrp_pkg::LenW + SyW;
    localparam int unsigned CW   = 13;   // wide enough for any depth or bound
    localparam int unsigned RCW  = 6;    // reduction counter, up to 63

    typedef logic [CW-1:0] t_cnt;

    // ---- control registers
    lrp_pkg::t_state    r_state, n_state;
    lrp_pkg::t_in_item  r_item, n_item;
    t_cnt               r_depth, n_depth;
    logic               r_active, n_active;
    logic [RCW-1:0]     r_reduces, n_reduces;
    logic [StW-1:0]     r_top, n_top;       // cached top of stack
    logic [StW-1:0]     r_val, n_val;       // production of current reduce
    t_cnt               r_base, n_base;
    logic [SyW-1:0]     r_head, n_head;
    logic               r_ovalid, n_ovalid;
    lrp_pkg::t_out_item r_out, n_out;

    // ---- memory ports
    logic           tbl_we,  rul_we,  stk_we;
    logic [TAW-1:0] tbl_wa,  tbl_ra;
    logic [TDW-1:0] tbl_wd,  tbl_rd;
    logic [RAW-1:0] rul_wa,  rul_ra;
    logic [RDW-1:0] rul_wd,  rul_rd;
    logic [KAW-1:0] stk_wa,  stk_ra;
    logic [StW-1:0] stk_wd,  stk_rd;

    lrp_mem #(.AW(TAW), .DW(TDW)) u_table (
        .i_clk(i_clk), .i_we(tbl_we), .i_waddr(tbl_wa), .i_wdata(tbl_wd),
        .i_raddr(tbl_ra), .o_rdata(tbl_rd));
    lrp_mem #(.AW(RAW), .DW(RDW)) u_rules (
        .i_clk(i_clk), .i_we(rul_we), .i_waddr(rul_wa), .i_wdata(rul_wd),
        .i_raddr(rul_ra), .o_rdata(rul_rd));
    lrp_mem #(.AW(KAW), .DW(StW)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));

    logic accept_in;
    logic out_free;
    assign out_free  = !r_ovalid || o_out.ready;
    assign accept_in = i_in.valid && i_in.ready;
    // Take a new item only once the result register is free this edge.
    assign i_in.ready = (r_state == lrp_pkg::ST_IDLE) && out_free;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // Flag lookups that fall outside the table; these read as error entries.
    logic tok_oob, top_oob, head_oob;
    logic lk_oob_q, lk_oob_d;
    assign tok_oob  = (32'(r_item.token) >= NUM_SYMBOLS);
    assign top_oob  = (32'(r_top) >= NUM_STATES);
    assign head_oob = (32'(r_head) >= NUM_SYMBOLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lrp_pkg::ST_IDLE;
            r_depth   <= '0;
            r_active  <= 1'b0;
            r_ovalid  <= 1'b0;
            r_reduces <= '0;
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_active  <= n_active;
            r_ovalid  <= n_ovalid;
            r_reduces <= n_reduces;
        end
        r_item   <= n_item;
        r_top    <= n_top;
        r_val    <= n_val;
        r_base   <= n_base;
        r_head   <= n_head;
        r_out    <= n_out;
        lk_oob_q <= lk_oob_d;
    end

    // Build a result from a depth and top state.
    function automatic lrp_pkg::t_out_item mk_out(
        input lrp_pkg::t_event ev, input logic [lrp_pkg::RuleW-1:0] prod,
        input logic [StW-1:0] top, input t_cnt depth, input logic lst);
        lrp_pkg::t_out_item o;
        o.event_res   = ev;
        o.production  = prod;
        o.state_after = (depth == '0) ? '0 : top;
        o.depth       = depth[DW-1:0];
        o.last        = lst;
        return o;
    endfunction

    logic [lrp_pkg::KindW-1:0] e_kind, g_kind;
    logic [StW-1:0]            e_val, g_val;
    logic [lrp_pkg::LenW-1:0]  rul_len;
    logic [SyW-1:0]            rul_hd;
    assign e_kind  = lk_oob_q ? lrp_pkg::KIND_ERROR : tbl_rd[TDW-1 -: lrp_pkg::KindW];
    assign e_val   = tbl_rd[StW-1:0];
    assign g_kind  = e_kind;
    assign g_val   = e_val;
    assign rul_len = rul_rd[RDW-1 -: lrp_pkg::LenW];
    assign rul_hd  = rul_rd[SyW-1:0];

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_depth   = r_depth;
        n_active  = r_active;
        n_reduces = r_reduces;
        n_top     = r_top;
        n_val     = r_val;
        n_base    = r_base;
        n_head    = r_head;
        n_out     = r_out;
        n_ovalid  = r_ovalid && !o_out.ready;
        lk_oob_d  = 1'b0;
        tbl_we = 1'b0; tbl_wa = '0; tbl_wd = '0;
        rul_we = 1'b0; rul_wa = '0; rul_wd = '0;
        stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
        // Default read address: action lookup for the cached top and token.
        tbl_ra = {r_top[SAW-1:0], r_item.token[YAW-1:0]};
        rul_ra = r_val[RAW-1:0];
        stk_ra = '0;

        case (r_state)
            lrp_pkg::ST_IDLE: begin
                if (accept_in) begin
                    n_item = i_in.data;
                    n_reduces = '0;
                    n_state = lrp_pkg::ST_EMIT;
                    case (lrp_pkg::t_act'(i_in.data.action))
                        lrp_pkg::ACT_WR_TABLE: begin
                            if (32'(i_in.data.table_state) < NUM_STATES &&
                                32'(i_in.data.table_symbol) < NUM_SYMBOLS) begin
                                tbl_we = 1'b1;
                            end
                            tbl_wa = {i_in.data.table_state[SAW-1:0],
                                      i_in.data.table_symbol[YAW-1:0]};
                            tbl_wd = {i_in.data.entry_kind, i_in.data.entry_value};
                            n_out = mk_out(lrp_pkg::EV_ACK, '0, r_top, r_depth, 1'b1);
                        end
                        lrp_pkg::ACT_WR_RULE: begin
                            rul_we = (32'(i_in.data.rule_index) < NUM_RULES);
                            rul_wa = i_in.data.rule_index[RAW-1:0];
                            rul_wd = {i_in.data.rule_length, i_in.data.rule_head};
                            n_out = mk_out(lrp_pkg::EV_ACK, '0, r_top, r_depth, 1'b1);
                        end
                        lrp_pkg::ACT_START: begin
                            stk_we   = 1'b1;
                            stk_wa   = '0;
                            stk_wd   = '0;
                            n_top    = '0;
                            n_depth  = t_cnt'(1);
                            n_active = 1'b1;
                            n_out = mk_out(lrp_pkg::EV_ACK, '0, '0, t_cnt'(1), 1'b1);
                        end
                        default: begin
                            if (!r_active) begin
                                n_out = mk_out(lrp_pkg::EV_IDLE, '0, r_top, r_depth,
                                               1'b1);
                            end else begin
                                n_state = lrp_pkg::ST_ACT_RD;
                                tbl_ra = {r_top[SAW-1:0], i_in.data.token[YAW-1:0]};
                                lk_oob_d = top_oob ||
                                    (32'(i_in.data.token) >= NUM_SYMBOLS);
                            end
                        end
                    endcase
                end
            end
            lrp_pkg::ST_EMIT: begin
                // Hand the pending result over, then return to idle.
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = lrp_pkg::ST_IDLE;
                end
            end
            lrp_pkg::ST_ACT_RD: begin
                // Action entry is on the read port; resolve it.
                if (out_free) begin
                    case (lrp_pkg::t_kind'(e_kind))
                        lrp_pkg::KIND_ERROR: begin
                            n_active = 1'b0;
                            n_out = mk_out(lrp_pkg::EV_SYNTAX, '0, r_top, r_depth, 1'b1);
                            n_ovalid = 1'b1;
                            n_state = lrp_pkg::ST_IDLE;
                        end
                        lrp_pkg::KIND_ACCEPT: begin
                            n_active = 1'b0;
                            n_out = mk_out(lrp_pkg::EV_ACCEPT, '0, r_top, r_depth, 1'b1);
                            n_ovalid = 1'b1;
                            n_state = lrp_pkg::ST_IDLE;
                        end
                        lrp_pkg::KIND_SHIFT: begin
                            if (r_depth >= t_cnt'(STACK_DEPTH)) begin
                                n_active = 1'b0;
                                n_out = mk_out(lrp_pkg::EV_STACK, '0, r_top, r_depth,
                                               1'b1);
                            end else begin
                                stk_we  = 1'b1;
                                stk_wa  = r_depth[KAW-1:0];
                                stk_wd  = e_val;
                                n_top   = e_val;
                                n_depth = r_depth + t_cnt'(1);
                                n_out = mk_out(lrp_pkg::EV_SHIFT, '0, e_val,
                                               r_depth + t_cnt'(1), 1'b1);
                            end
                            n_ovalid = 1'b1;
                            n_state = lrp_pkg::ST_IDLE;
                        end
                        default: begin
                            if (32'(r_reduces) >= MAX_REDUCES) begin
                                n_active = 1'b0;
                                n_out = mk_out(lrp_pkg::EV_STACK, '0, r_top, r_depth,
                                               1'b1);
                                n_ovalid = 1'b1;
                                n_state = lrp_pkg::ST_IDLE;
                            end else if (32'(e_val) >= NUM_RULES) begin
                                n_active = 1'b0;
                                n_out = mk_out(lrp_pkg::EV_SYNTAX, '0, r_top, r_depth,
                                               1'b1);
                                n_ovalid = 1'b1;
                                n_state = lrp_pkg::ST_IDLE;
                            end else begin
                                n_val  = e_val;
                                rul_ra = e_val[RAW-1:0];
                                n_state = lrp_pkg::ST_RULE_RD;
                            end
                        end
                    endcase
                end
            end
            lrp_pkg::ST_RULE_RD: begin
                // Rule on the read port; check and fetch the exposed state.
                n_head = rul_hd;
                n_base = r_depth - t_cnt'(rul_len);
                stk_ra = KAW'(r_depth - t_cnt'(rul_len) - t_cnt'(1));
                if (rul_hd == '0 || 32'(rul_hd) >= NUM_SYMBOLS) begin
                    n_active = 1'b0;
                    n_out = mk_out(lrp_pkg::EV_BAD_GOTO, '0, r_top, r_depth, 1'b1);
                    n_state = lrp_pkg::ST_EMIT;
                end else if (t_cnt'(rul_len) >= r_depth ||
                             r_depth - t_cnt'(rul_len) >= t_cnt'(STACK_DEPTH)) begin
                    n_active = 1'b0;
                    n_out = mk_out(lrp_pkg::EV_STACK, '0, r_top, r_depth, 1'b1);
                    n_state = lrp_pkg::ST_EMIT;
                end else begin
                    n_state = lrp_pkg::ST_GOTO_RD;
                end
            end
            lrp_pkg::ST_GOTO_RD: begin
                // Exposed state is on the stack port; issue the goto lookup.
                tbl_ra = {stk_rd[SAW-1:0], r_head[YAW-1:0]};
                lk_oob_d = (32'(stk_rd) >= NUM_STATES) || head_oob;
                n_state = lrp_pkg::ST_GOTO_EV;
            end
            lrp_pkg::ST_GOTO_EV: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (g_kind != lrp_pkg::KIND_SHIFT) begin
                        n_active = 1'b0;
                        n_out = mk_out(lrp_pkg::EV_BAD_GOTO, '0, r_top, r_depth, 1'b1);
                        n_state = lrp_pkg::ST_IDLE;
                    end else begin
                        stk_we    = 1'b1;
                        stk_wa    = r_base[KAW-1:0];
                        stk_wd    = g_val;
                        n_top     = g_val;
                        n_depth   = r_base + t_cnt'(1);
                        n_reduces = r_reduces + RCW'(1);
                        n_out = mk_out(lrp_pkg::EV_REDUCE, r_val[lrp_pkg::RuleW-1:0],
                                       g_val, r_base + t_cnt'(1), 1'b0);
                        // Repeat the action lookup with the new top.
                        tbl_ra = {g_val[SAW-1:0], r_item.token[YAW-1:0]};
                        lk_oob_d = (32'(g_val) >= NUM_STATES) || tok_oob;
                        n_state = lrp_pkg::ST_ACT_RD;
                    end
                end else begin
                    // Hold the goto read result by re-reading it.
                    tbl_ra = {stk_rd[SAW-1:0], r_head[YAW-1:0]};
                    lk_oob_d = lk_oob_q;
                    stk_ra = KAW'(r_base - t_cnt'(1));
                end
            end
            default: n_state = lrp_pkg::ST_IDLE;
        endcase
        // Keep stack read pointed at the exposed entry while waiting.
        if (r_state == lrp_pkg::ST_GOTO_RD) begin
            stk_ra = KAW'(r_base - t_cnt'(1));
        end
        // Keep the action entry stable while the output is stalled.
        if (r_state == lrp_pkg::ST_ACT_RD && !out_free) begin
            lk_oob_d = lk_oob_q;
        end
        // Keep the rule read stable for the next cycle.
        if (r_state == lrp_pkg::ST_RULE_RD) begin
            rul_ra = r_val[RAW-1:0];
        end
    end

    // Stack depth never exceeds the configured depth.
    `LRP_ASSERT_IMPLY(a_depth_bound, i_clk, i_rst_n, 1'b1,
        r_depth <= t_cnt'(STACK_DEPTH))
    // No input is taken while an item is being worked.
    `LRP_ASSERT_IMPLY(a_no_accept_busy, i_clk, i_rst_n,
        r_state != lrp_pkg::ST_IDLE, !i_in.ready)
    // A reduce event always leaves the parse armed.
    `LRP_ASSERT_IMPLY(a_reduce_active, i_clk, i_rst_n,
        r_ovalid && r_out.event_res == lrp_pkg::EV_REDUCE, r_active)
endmodule

/* tb/tb_lr_shift_reduce_parser.sv */
// ----------------------------------------------------------------------------
// tb_lr_shift_reduce_parser
// Self-checking bench for the LR parser driver. A directed table covers the
// extremes of the fields, every action and every error path. A random part
// follows: small grammars with random content, parse runs and some noise.
// Results are checked field by field with the model or a typed row's set result.
// ----------------------------------------------------------------------------
module tb_lr_shift_reduce_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NStates   = 256;
    localparam int NSyms     = 64;
    localparam int NRules    = 128;
    localparam int StackMax  = 64;
    localparam int ReduceMax = 63;
    localparam int Region    = 8;      // states and symbols of the random grammar
    localparam int NumItems  = 220;
    localparam int IdleLimit = 20000;
    localparam int StW       = lrp_pkg::StateW;
    localparam int SyW       = lrp_pkg::SymW;
    localparam int RuW       = lrp_pkg::RuleW;
    localparam int LnW       = lrp_pkg::LenW;
    localparam int DpW       = lrp_pkg::DepthW;

    typedef struct {
        lrp_pkg::t_in_item  item;
        bit                 typed;
        lrp_pkg::t_out_item res;
        int                 reps;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    lrp_in_if  in_ch ();
    lrp_out_if out_ch ();

    lr_shift_reduce_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Parser image: tables with written flags, stack, depth and parse flag.
    logic [9:0]     tab_mem [NStates*NSyms];
    bit             tab_set [NStates*NSyms];
    logic [9:0]     rule_mem [NRules];
    bit             rule_set [NRules];
    logic [StW-1:0] stk_mem [StackMax];
    int             stk_depth;
    bit             parsing;

    lrp_pkg::t_out_item step_res[$];     // results of the last modeled item
    lrp_pkg::t_out_item pending_res[$];  // results awaited from the block
    t_dir_row           dir_rows[$];
    bit        failed;
    int        idle_cycles;
    int        stall_left;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // Append one modeled result; state, depth and last are stamped later.
    task automatic put_res(input lrp_pkg::t_event ev, input logic [RuW-1:0] prod);
        lrp_pkg::t_out_item r;
        r = '0;
        r.event_res = ev;
        r.production = prod;
        step_res.insert(step_res.size(), r);
    endtask

    // Model one item. Tokens run on a copy of the stack; commit writes it back.
    // ok drops when the item would read a table or rule entry never set.
    task automatic parse_item(input lrp_pkg::t_in_item it, input bit commit,
                              output bit ok);
        logic [StW-1:0] lstk [StackMax];
        int   ldepth, reduces, base, top, idx, len, head;
        bit   lact, done, was_idle;
        logic [9:0] ent, gent;
        ok = 1'b1;
        lstk = stk_mem;
        ldepth = stk_depth;
        lact = parsing;
        reduces = 0;
        was_idle = 1'b0;
        step_res.delete();
        case (lrp_pkg::t_act'(it.action))
            lrp_pkg::ACT_WR_TABLE: begin
                if (commit) begin
                    idx = it.table_state * NSyms + it.table_symbol;
                    tab_mem[idx] = {it.entry_kind, it.entry_value};
                    tab_set[idx] = 1'b1;
                end
                put_res(lrp_pkg::EV_ACK, '0);
            end
            lrp_pkg::ACT_WR_RULE: begin
                if (commit) begin
                    rule_mem[it.rule_index] = {it.rule_length, it.rule_head};
                    rule_set[it.rule_index] = 1'b1;
                end
                put_res(lrp_pkg::EV_ACK, '0);
            end
            lrp_pkg::ACT_START: begin
                lstk[0] = '0;
                ldepth = 1;
                lact = 1'b1;
                put_res(lrp_pkg::EV_ACK, '0);
            end
            default: begin
                if (!lact) begin
                    was_idle = 1'b1;
                    put_res(lrp_pkg::EV_IDLE, '0);
                end else begin
                    done = 1'b0;
                    while (!done && ok) begin
                        top = (ldepth == 0) ? 0 : lstk[ldepth-1];
                        idx = top * NSyms + it.token;
                        ok = tab_set[idx];
                        ent = tab_mem[idx];
                        done = 1'b1;
                        case (lrp_pkg::t_kind'(ent[9:8]))
                            lrp_pkg::KIND_ERROR: begin
                                lact = 1'b0;
                                put_res(lrp_pkg::EV_SYNTAX, '0);
                            end
                            lrp_pkg::KIND_ACCEPT: begin
                                lact = 1'b0;
                                put_res(lrp_pkg::EV_ACCEPT, '0);
                            end
                            lrp_pkg::KIND_SHIFT: begin
                                if (ldepth >= StackMax) begin
                                    lact = 1'b0;
                                    put_res(lrp_pkg::EV_STACK, '0);
                                end else begin
                                    lstk[ldepth] = ent[7:0];
                                    ldepth++;
                                    put_res(lrp_pkg::EV_SHIFT, '0);
                                end
                            end
                            default: begin
                                if (reduces >= ReduceMax) begin
                                    lact = 1'b0;
                                    put_res(lrp_pkg::EV_STACK, '0);
                                end else if (ent[7:0] >= NRules) begin
                                    lact = 1'b0;
                                    put_res(lrp_pkg::EV_SYNTAX, '0);
                                end else begin
                                    ok = rule_set[ent[6:0]];
                                    len = rule_mem[ent[6:0]][9:6];
                                    head = rule_mem[ent[6:0]][5:0];
                                    if (head == 0) begin
                                        lact = 1'b0;
                                        put_res(lrp_pkg::EV_BAD_GOTO, '0);
                                    end else if (len >= ldepth ||
                                                 ldepth - len >= StackMax) begin
                                        lact = 1'b0;
                                        put_res(lrp_pkg::EV_STACK, '0);
                                    end else begin
                                        base = ldepth - len;
                                        idx = lstk[base-1] * NSyms + head;
                                        ok = ok && tab_set[idx];
                                        gent = tab_mem[idx];
                                        if (lrp_pkg::t_kind'(gent[9:8]) !=
                                            lrp_pkg::KIND_SHIFT) begin
                                            lact = 1'b0;
                                            put_res(lrp_pkg::EV_BAD_GOTO, '0);
                                        end else begin
                                            lstk[base] = gent[7:0];
                                            ldepth = base + 1;
                                            reduces++;
                                            put_res(lrp_pkg::EV_REDUCE, ent[6:0]);
                                            done = 1'b0;
                                        end
                                    end
                                end
                            end
                        endcase
                        // stamp stack top and depth as they stand after this event
                        step_res[$].state_after = (ldepth == 0) ? '0 : lstk[ldepth-1];
                        step_res[$].depth = ldepth[DpW-1:0];
                    end
                end
            end
        endcase
        if (step_res.size() > 0 && (it.action != lrp_pkg::ACT_TOKEN || was_idle)) begin
            step_res[$].state_after = (ldepth == 0) ? '0 : lstk[ldepth-1];
            step_res[$].depth = ldepth[DpW-1:0];
        end
        if (step_res.size() > 0)
            step_res[$].last = 1'b1;
        if (commit && ok) begin
            stk_mem = lstk;
            stk_depth = ldepth;
            parsing = lact;
        end
    endtask

    // Items with random filler in the fields the action ignores.
    function automatic lrp_pkg::t_in_item noise_item(lrp_pkg::t_act a);
        lrp_pkg::t_in_item it;
        logic [63:0]       raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(lrp_pkg::t_in_item)-1:0];
        it.action = a;
        return it;
    endfunction

    function automatic lrp_pkg::t_in_item tab_wr(int st, int sym, lrp_pkg::t_kind k,
                                                 int val);
        lrp_pkg::t_in_item it;
        it = noise_item(lrp_pkg::ACT_WR_TABLE);
        it.table_state = StW'(st);
        it.table_symbol = SyW'(sym);
        it.entry_kind = k;
        it.entry_value = StW'(val);
        return it;
    endfunction

    function automatic lrp_pkg::t_in_item rule_wr(int idx, int len, int head);
        lrp_pkg::t_in_item it;
        it = noise_item(lrp_pkg::ACT_WR_RULE);
        it.rule_index = RuW'(idx);
        it.rule_length = LnW'(len);
        it.rule_head = SyW'(head);
        return it;
    endfunction

    function automatic lrp_pkg::t_in_item tok_item(int t);
        lrp_pkg::t_in_item it;
        it = noise_item(lrp_pkg::ACT_TOKEN);
        it.token = SyW'(t);
        return it;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(30, 10);
    endfunction

    // Hold the item until the transfer, then leave valid high at the falling edge.
    task automatic send_item(input lrp_pkg::t_in_item it);
        in_ch.valid = 1'b1;
        in_ch.data = it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic gap_after();
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // Model, queue the expectations, then drive.
    task automatic issue(input lrp_pkg::t_in_item it);
        bit ok;
        parse_item(it, 1'b1, ok);
        foreach (step_res[k]) pending_res.insert(pending_res.size(), step_res[k]);
        send_item(it);
        gap_after();
    endtask

    task automatic add_row(lrp_pkg::t_in_item it, bit typed = 0,
                           lrp_pkg::t_event ev = lrp_pkg::EV_ACK,
                           int st = 0, int dp = 0, int reps = 1);
        t_dir_row r;
        r.item = it;
        r.typed = typed;
        r.res.event_res = ev;
        r.res.production = '0;
        r.res.state_after = StW'(st);
        r.res.depth = DpW'(dp);
        r.res.last = 1'b1;
        r.reps = reps;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // Receiver stalls, some long, with quiet stretches in between.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(99) < 20)
                stall_left <= gap_len();
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        lrp_pkg::t_out_item want;
        lrp_pkg::t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_res.size() == 0) begin
                $error("unexpected result ev=%0d", got.event_res);
                failed = 1'b1;
            end else begin
                want = pending_res.pop_front();
                if (got.event_res !== want.event_res) begin
                    $error("event_res exp %0d got %0d", want.event_res, got.event_res);
                    failed = 1'b1;
                end
                if (got.production !== want.production) begin
                    $error("production exp %0d got %0d", want.production, got.production);
                    failed = 1'b1;
                end
                if (got.state_after !== want.state_after) begin
                    $error("state_after exp %0d got %0d",
                           want.state_after, got.state_after);
                    failed = 1'b1;
                end
                if (got.depth !== want.depth) begin
                    $error("depth exp %0d got %0d", want.depth, got.depth);
                    failed = 1'b1;
                end
                if (got.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("tb_lr_shift_reduce_parser failed");
            $finish;
        end
    end

    initial begin
        lrp_pkg::t_in_item it;
        lrp_pkg::t_in_item trial;
        bit   ok;
        int   sent, run_len, tries;
        bit   paused;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        failed = 1'b0;
        stk_depth = 0;
        parsing = 1'b0;
        foreach (tab_set[k]) tab_set[k] = 1'b0;
        foreach (rule_set[k]) rule_set[k] = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: idle token, field extremes, each error path, long chains.
        add_row(tok_item(5), 1, lrp_pkg::EV_IDLE, 0, 0);
        add_row(tab_wr(255, 63, lrp_pkg::KIND_ACCEPT, 255), 1, lrp_pkg::EV_ACK, 0, 0);
        add_row(rule_wr(127, 15, 63), 1, lrp_pkg::EV_ACK, 0, 0);
        add_row(tab_wr(0, 63, lrp_pkg::KIND_ACCEPT, 0));
        add_row(noise_item(lrp_pkg::ACT_START), 1, lrp_pkg::EV_ACK, 0, 1);
        add_row(tok_item(63), 1, lrp_pkg::EV_ACCEPT, 0, 1);
        add_row(tab_wr(0, 1, lrp_pkg::KIND_ERROR, 0));
        add_row(noise_item(lrp_pkg::ACT_START));
        add_row(tok_item(1), 1, lrp_pkg::EV_SYNTAX, 0, 1);
        // reduce loop that never ends: runs into the chained-reduction limit
        add_row(tab_wr(0, 2, lrp_pkg::KIND_SHIFT, 3));
        add_row(tab_wr(3, 2, lrp_pkg::KIND_REDUCE, 1));
        add_row(rule_wr(1, 1, 5));
        add_row(tab_wr(0, 5, lrp_pkg::KIND_SHIFT, 3));
        add_row(noise_item(lrp_pkg::ACT_START));
        add_row(tok_item(2));
        add_row(tok_item(2));
        // head column zero
        add_row(rule_wr(2, 0, 0));
        add_row(tab_wr(3, 4, lrp_pkg::KIND_REDUCE, 2));
        add_row(noise_item(lrp_pkg::ACT_START));
        add_row(tok_item(2));
        add_row(tok_item(4), 1, lrp_pkg::EV_BAD_GOTO, 3, 2);
        // production number out of range
        add_row(tab_wr(3, 6, lrp_pkg::KIND_REDUCE, 200));
        add_row(noise_item(lrp_pkg::ACT_START));
        add_row(tok_item(2));
        add_row(tok_item(6));
        // stack underflow
        add_row(rule_wr(3, 2, 5));
        add_row(tab_wr(3, 7, lrp_pkg::KIND_REDUCE, 3));
        add_row(noise_item(lrp_pkg::ACT_START));
        add_row(tok_item(2));
        add_row(tok_item(7));
        // goto entry that is not a shift
        add_row(rule_wr(5, 1, 11));
        add_row(tab_wr(0, 11, lrp_pkg::KIND_REDUCE, 0));
        add_row(tab_wr(3, 12, lrp_pkg::KIND_REDUCE, 5));
        add_row(noise_item(lrp_pkg::ACT_START));
        add_row(tok_item(2));
        add_row(tok_item(12));
        // stack overflow by repeated shifts
        add_row(tab_wr(3, 8, lrp_pkg::KIND_SHIFT, 3));
        add_row(noise_item(lrp_pkg::ACT_START));
        add_row(tok_item(2));
        add_row(tok_item(8), 0, lrp_pkg::EV_ACK, 0, 0, 64);

        sent = 0;
        foreach (dir_rows[r]) begin
            for (int n = 0; n < dir_rows[r].reps; n++) begin
                if (dir_rows[r].typed) begin
                    parse_item(dir_rows[r].item, 1'b1, ok);
                    pending_res.insert(pending_res.size(), dir_rows[r].res);
                    send_item(dir_rows[r].item);
                    gap_after();
                end else begin
                    issue(dir_rows[r].item);
                end
                sent++;
            end
        end

        // Random: fill a small grammar, then parse runs with rewrites and noise.
        for (int s = 0; s < Region; s++) begin
            for (int y = 0; y < Region; y++) begin
                issue(tab_wr(s, y, lrp_pkg::t_kind'($urandom_range(3)),
                             $urandom_range(Region-1)));
                sent++;
            end
            issue(rule_wr(s, $urandom_range(3),
                          ($urandom_range(9) == 0) ? 0 : $urandom_range(Region-1, 1)));
            sent++;
        end
        paused = 1'b0;
        while (sent < NumItems) begin
            if (!paused && sent > NumItems / 2) begin
                // let the block drain completely before going on
                paused = 1'b1;
                in_ch.valid = 1'b0;
                while (pending_res.size() != 0) @(negedge i_clk);
            end
            case ($urandom_range(9))
                0: it = tab_wr($urandom_range(Region-1), $urandom_range(Region-1),
                               lrp_pkg::t_kind'($urandom_range(3)),
                               $urandom_range(Region-1));
                1: it = rule_wr($urandom_range(Region-1), $urandom_range(3),
                                $urandom_range(Region-1));
                2: it = tok_item($urandom_range(63));  // idle noise when not parsing
                default: it = noise_item(lrp_pkg::ACT_START);
            endcase
            if (it.action == lrp_pkg::ACT_TOKEN && parsing)
                it = noise_item(lrp_pkg::ACT_START);
            issue(it);
            sent++;
            if (it.action == lrp_pkg::ACT_START) begin
                run_len = $urandom_range(14, 2);
                while (parsing && run_len > 0 && sent < NumItems) begin
                    tries = 0;
                    ok = 1'b0;
                    while (!ok && tries < 12) begin
                        trial = tok_item(($urandom_range(9) == 0) ? $urandom_range(63)
                                                                  : $urandom_range(Region-1));
                        parse_item(trial, 1'b0, ok);
                        tries++;
                    end
                    if (!ok) break;
                    issue(trial);
                    sent++;
                    run_len--;
                end
            end
        end

        in_ch.valid = 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed) begin
            $display("tb_lr_shift_reduce_parser passed");
        end else begin
            $display("tb_lr_shift_reduce_parser failed");
        end
        $finish;
    end

endmodule
